### rtl/core/speed_clamped_motion_integrator_macros.svh
// Assertion macros for the motion integrator.
`ifndef SPEED_CLAMPED_MOTION_INTEGRATOR_MACROS_SVH
`define SPEED_CLAMPED_MOTION_INTEGRATOR_MACROS_SVH
`ifndef SYNTH
`define SCMI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SCMI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SCMI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SCMI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/scmi_pkg.sv
// Shared types and constants of the motion integrator.
`default_nettype none
package scmi_pkg;
  localparam int FRAC_BITS = 16;
  localparam int W = 32;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_LOAD_POS = 2'd1,
    OP_LOAD_VEL = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the request and apply loads
    logic square_x;    // square |vx| into the accumulator
    logic square_y;    // add |vy|^2 into the accumulator
    logic cmp_start;   // compute the limit square and compare
    logic sqrt_start;  // start the root over the accumulator
    logic sqrt_step;
    logic div_start;   // start dividing |vx|*lim by the magnitude
    logic div_step;
    logic div_take_x;  // store the x quotient, start the y divide
    logic div_take_y;
    logic integrate;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic do_clamp;
    logic sqrt_done;
    logic div_done;
  } status_t;
endpackage
`default_nettype wire

### rtl/core/scmi_if.sv
// Valid/ready channel interfaces of the motion integrator.
`default_nettype none
interface scmi_in_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic signed [31:0] value_x;
  logic signed [31:0] value_y;
  modport source (output valid, operation, value_x, value_y, input ready);
  modport sink (input valid, operation, value_x, value_y, output ready);
endinterface

interface scmi_out_if (input wire logic clk);
  logic valid;
  logic ready;
  logic signed [31:0] position_x_out;
  logic signed [31:0] position_y_out;
  logic signed [31:0] velocity_x_out;
  logic signed [31:0] velocity_y_out;
  logic [30:0] speed_out;
  modport source (output valid, position_x_out, position_y_out, velocity_x_out,
                  velocity_y_out, speed_out, input ready);
  modport sink (input valid, position_x_out, position_y_out, velocity_x_out,
                velocity_y_out, speed_out, output ready);
endinterface

interface scmi_cfg_if (input wire logic clk);
  logic valid;
  logic ready;
  logic signed [31:0] max_speed;
  modport source (output valid, max_speed, input ready);
  modport sink (input valid, max_speed, output ready);
endinterface
`default_nettype wire

### rtl/core/speed_clamped_motion_integrator.sv
// Top level of the speed-clamped motion integrator.
`default_nettype none
// Without a clamp a request runs the 32-step root over the squared speed; with one it
// also runs two 64-step restoring divides, one bit per cycle. A finished result waits
// in the output register; the next request is accepted only once the previous one is
// delivered. The speed limit may be written at any time the block is idle.
`include "speed_clamped_motion_integrator_macros.svh"
module speed_clamped_motion_integrator
  import scmi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  scmi_in_if.sink in_ch,
  scmi_out_if.source out_ch,
  scmi_cfg_if.sink cfg_ch
);
  cmd_t cmd;
  status_t sts;
  logic signed [31:0] max_speed_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) max_speed_r <= '0;
    else if (cfg_ch.valid) max_speed_r <= cfg_ch.max_speed;
  end

  scmi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  scmi_datapath u_dp (
    .clk(clk), .cmd(cmd), .sts(sts),
    .in_operation(in_ch.operation), .in_value_x(in_ch.value_x),
    .in_value_y(in_ch.value_y), .max_speed(max_speed_r), .rst_n(rst_n),
    .res_px(out_ch.position_x_out), .res_py(out_ch.position_y_out),
    .res_vx(out_ch.velocity_x_out), .res_vy(out_ch.velocity_y_out),
    .res_speed(out_ch.speed_out)
  );

  `SCMI_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, out_ch.valid && !out_ch.ready, !in_ch.ready)
  `SCMI_ASSERT_NEXT(a_accept_clears_ready, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `SCMI_ASSERT_NEXT(a_accept_no_result, clk, rst_n, in_ch.valid && in_ch.ready, !cmd.result_load)
endmodule
`default_nettype wire

### rtl/core/scmi_datapath.sv
// Datapath: state registers, squarer, root and divide units, saturating adders.
`default_nettype none
module scmi_datapath
  import scmi_pkg::*;
(
  input  wire logic clk,
  input  wire cmd_t cmd,
  output status_t sts,
  input  wire logic [1:0] in_operation,
  input  wire logic signed [31:0] in_value_x,
  input  wire logic signed [31:0] in_value_y,
  input  wire logic signed [31:0] max_speed,
  input  wire logic rst_n,
  output logic signed [31:0] res_px,
  output logic signed [31:0] res_py,
  output logic signed [31:0] res_vx,
  output logic signed [31:0] res_vy,
  output logic [30:0] res_speed
);
  logic signed [31:0] px_r, py_r, vx_r, vy_r;
  logic [1:0] op_r;
  logic [64:0] acc_r;
  logic [64:0] rem_r;
  logic [32:0] root_r;
  logic [5:0] scnt_r;
  logic do_clamp_r;
  logic [63:0] dividend_r;
  logic [32:0] drem_r;
  logic [6:0] dcnt_r;
  logic [63:0] quo_x_r;
  logic [32:0] magn;
  logic [31:0] ax, ay, lim_abs, sq_in;
  logic [63:0] sq;
  logic [63:0] lim_sq;
  logic [66:0] trial;
  logic [33:0] dtrial;
  logic [32:0] dshift;
  logic [63:0] quo_r;
  logic signed [32:0] sum_x, sum_y;

  function automatic logic signed [31:0] sat_q(input logic [63:0] q, input logic neg);
    logic signed [64:0] r;
    begin
      r = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      if (r > 65'sh0_7FFF_FFFF) sat_q = 32'sh7FFF_FFFF;
      else if (r < -65'sh0_8000_0000) sat_q = 32'sh8000_0000;
      else sat_q = r[31:0];
    end
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [32:0] s);
    begin
      if (s[32] != s[31]) sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else sat_add = s[31:0];
    end
  endfunction

  assign ax = vx_r[31] ? 32'(-vx_r) : vx_r;
  assign ay = vy_r[31] ? 32'(-vy_r) : vy_r;
  assign lim_abs = max_speed[31] ? 32'(-max_speed) : max_speed;
  assign sq_in = cmd.square_x ? ax : (cmd.cmp_start ? lim_abs : ay);
  assign sq = sq_in * sq_in;
  assign lim_sq = sq;
  assign magn = root_r;

  // Restoring root, two radicand bits per step, 32 steps over the low 64 bits;
  // the sum of two squares never exceeds 2^63.
  assign trial = {rem_r[64:0], acc_r[63:62]} - {root_r, 2'b01};
  assign dshift = {drem_r[31:0], dividend_r[63]};
  assign dtrial = {1'b0, dshift} - {1'b0, magn};

  assign sum_x = 33'(px_r) + 33'(vx_r);
  assign sum_y = 33'(py_r) + 33'(vy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
      py_r <= '0;
      vx_r <= '0;
      vy_r <= '0;
      op_r <= OP_NOP;
      do_clamp_r <= 1'b0;
      scnt_r <= '0;
      dcnt_r <= '0;
    end else begin
      if (cmd.capture) begin
        op_r <= in_operation;
        if (in_operation == OP_LOAD_POS) begin
          px_r <= in_value_x;
          py_r <= in_value_y;
        end else if (in_operation == OP_LOAD_VEL) begin
          vx_r <= in_value_x;
          vy_r <= in_value_y;
        end
      end
      if (cmd.square_x) acc_r <= {1'b0, sq};
      if (cmd.square_y) acc_r <= acc_r + {1'b0, sq};
      if (cmd.cmp_start)
        do_clamp_r <= (op_r == OP_TICK) && (max_speed != '0) && (acc_r > {1'b0, lim_sq});
      if (cmd.sqrt_start) begin
        rem_r <= '0;
        root_r <= '0;
        scnt_r <= 6'd32;
      end else if (cmd.sqrt_step && scnt_r != '0) begin
        acc_r <= {acc_r[62:0], 2'b00};
        scnt_r <= scnt_r - 6'd1;
        if (!trial[66]) begin
          rem_r <= trial[64:0];
          root_r <= {root_r[31:0], 1'b1};
        end else begin
          rem_r <= {rem_r[62:0], acc_r[63:62]};
          root_r <= {root_r[31:0], 1'b0};
        end
      end
      if (cmd.div_start || cmd.div_take_x) begin
        dividend_r <= (cmd.div_start ? ax : ay) * lim_abs;
        drem_r <= '0;
        quo_r <= '0;
        dcnt_r <= 7'd64;
      end else if (cmd.div_step && dcnt_r != '0) begin
        dividend_r <= {dividend_r[62:0], 1'b0};
        dcnt_r <= dcnt_r - 7'd1;
        if (!dtrial[33]) begin
          drem_r <= dtrial[32:0];
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          drem_r <= dshift;
          quo_r <= {quo_r[62:0], 1'b0};
        end
      end
      if (cmd.div_take_x) quo_x_r <= quo_r;
      if (cmd.div_take_y) begin
        vx_r <= sat_q(quo_x_r, vx_r[31] ^ max_speed[31]);
        vy_r <= sat_q(quo_r, vy_r[31] ^ max_speed[31]);
      end
      if (cmd.integrate) begin
        px_r <= sat_add(sum_x);
        py_r <= sat_add(sum_y);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      res_px <= px_r;
      res_py <= py_r;
      res_vx <= vx_r;
      res_vy <= vy_r;
      res_speed <= root_r[32:31] != 2'b00 ? 31'h7FFF_FFFF : root_r[30:0];
    end
  end

  assign sts.is_tick = (op_r == OP_TICK);
  assign sts.do_clamp = do_clamp_r && (root_r != '0);
  assign sts.sqrt_done = (scnt_r == '0);
  assign sts.div_done = (dcnt_r == '0);
endmodule
`default_nettype wire

### rtl/core/scmi_ctrl.sv
// Controller state machine sequencing the datapath for each request.
`default_nettype none
module scmi_ctrl
  import scmi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire status_t sts,
  output cmd_t cmd
);
  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_SQX    = 13'b0000000000010,
    S_SQY    = 13'b0000000000100,
    S_CMP    = 13'b0000000001000,
    S_ROOT0  = 13'b0000000010000,
    S_ROOT   = 13'b0000000100000,
    S_DIVX0  = 13'b0000001000000,
    S_DIVX   = 13'b0000010000000,
    S_DIVY   = 13'b0000100000000,
    S_INT    = 13'b0001000000000,
    S_SQX2   = 13'b0010000000000,
    S_FIN0   = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic root2_r, root2_nxt;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    root2_nxt = root2_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          root2_nxt = 1'b0;
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        cmd.square_x = 1'b1;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.square_y = 1'b1;
        state_nxt = root2_r ? S_ROOT0 : S_CMP;
      end
      S_CMP: begin
        cmd.cmp_start = 1'b1;
        state_nxt = S_ROOT0;
      end
      S_ROOT0: begin
        cmd.sqrt_start = 1'b1;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_done) begin
          cmd.sqrt_step = 1'b0;
          if (root2_r) state_nxt = S_FIN;
          else if (!sts.is_tick) state_nxt = S_FIN;
          else if (sts.do_clamp) state_nxt = S_DIVX0;
          else state_nxt = S_INT;
        end
      end
      S_DIVX0: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIVX;
      end
      S_DIVX: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.div_step = 1'b0;
          cmd.div_take_x = 1'b1;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.div_step = 1'b0;
          cmd.div_take_y = 1'b1;
          state_nxt = S_INT;
        end
      end
      S_INT: begin
        cmd.integrate = 1'b1;
        root2_nxt = 1'b1;
        state_nxt = S_SQX2;
      end
      S_SQX2: begin
        // Velocity may have changed; recompute the reported magnitude.
        state_nxt = sts.do_clamp ? S_SQX : S_FIN0;
      end
      S_FIN0: state_nxt = S_FIN;
      S_FIN: begin
        cmd.result_load = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      root2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      root2_r <= root2_nxt;
    end
  end
endmodule
`default_nettype wire

### tb/speed_clamped_motion_integrator_tb.sv
// Testbench for the speed-clamped motion integrator: directed and random requests checked against a predictor.
`default_nettype none
module tb;
  import scmi_pkg::*;

  class motion_scoreboard;
    logic signed [31:0] limit;
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
    logic [159:0] pending[$];
    int errors;

    function new();
      limit = 0;
      pos_x = 0;
      pos_y = 0;
      vel_x = 0;
      vel_y = 0;
      errors = 0;
    endfunction

    function logic [63:0] root64(logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function logic signed [31:0] sat(logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function logic [63:0] mag_sq();
      logic [63:0] ax, ay;
      ax = vel_x < 0 ? -64'(vel_x) : 64'(vel_x);
      ay = vel_y < 0 ? -64'(vel_y) : 64'(vel_y);
      return ax * ax + ay * ay;
    endfunction

    function logic signed [31:0] rescaled(logic signed [31:0] c, logic [63:0] lim_abs,
                                          logic [63:0] mag);
      logic [63:0] a, q;
      logic signed [65:0] r;
      a = c < 0 ? -64'(c) : 64'(c);
      q = (a * lim_abs) / mag;
      r = ((c < 0) != (limit < 0)) ? -$signed({2'b0, q}) : $signed({2'b0, q});
      return sat(r);
    endfunction

    function void note_request(op_t op, logic signed [31:0] vx, logic signed [31:0] vy);
      logic [63:0] lim_abs, sum, mag, spd;
      case (op)
        OP_TICK: begin
          if (limit != 0) begin
            lim_abs = limit < 0 ? -64'(limit) : 64'(limit);
            sum = mag_sq();
            if (sum > lim_abs * lim_abs) begin
              mag = root64(sum);
              if (mag != 0) begin
                vel_x = rescaled(vel_x, lim_abs, mag);
                vel_y = rescaled(vel_y, lim_abs, mag);
              end
            end
          end
          pos_x = sat(66'(pos_x) + 66'(vel_x));
          pos_y = sat(66'(pos_y) + 66'(vel_y));
        end
        OP_LOAD_POS: begin
          pos_x = vx;
          pos_y = vy;
        end
        OP_LOAD_VEL: begin
          vel_x = vx;
          vel_y = vy;
        end
        default: ;
      endcase
      spd = root64(mag_sq());
      if (spd > 64'h7fffffff) spd = 64'h7fffffff;
      pending.push_back({pos_x, pos_y, vel_x, vel_y, 1'b0, spd[30:0]});
    endfunction

    function void check_result(logic [159:0] got);
      logic [159:0] exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      for (int f = 0; f < 5; f++) begin
        if (exp_r[159 - 32*f -: 32] !== got[159 - 32*f -: 32]) begin
          errors++;
          if (errors <= 10)
            $display("field %0d: expected %h, got %h", f, exp_r[159 - 32*f -: 32],
                     got[159 - 32*f -: 32]);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  scmi_in_if in_ch (clk);
  scmi_out_if out_ch (clk);
  scmi_cfg_if cfg_ch (clk);
  motion_scoreboard board = new();
  bit quiet_phase = 0;
  int hold_cycles = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  speed_clamped_motion_integrator i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  initial begin
    in_ch.valid = 0;
    in_ch.operation = 0;
    in_ch.value_x = 0;
    in_ch.value_y = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.max_speed = 0;
  end

  // Result side: random stalls, plus one long hold-off driven by hold_cycles.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result({out_ch.position_x_out, out_ch.position_y_out,
                          out_ch.velocity_x_out, out_ch.velocity_y_out,
                          1'b0, out_ch.speed_out});
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= quiet_phase || ($urandom_range(99) >= 6);
    end
  end

  // Valid stays high between back-to-back requests; it drops only on an idle cycle.
  task automatic send_request(op_t op, logic signed [31:0] vx, logic signed [31:0] vy);
    while (!quiet_phase && $urandom_range(99) < 6) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.operation <= op;
    in_ch.value_x <= vx;
    in_ch.value_y <= vy;
    do @(posedge clk); while (!in_ch.ready);
    board.note_request(op, vx, vy);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_limit(logic signed [31:0] lim);
    drain();
    cfg_ch.valid <= 1;
    cfg_ch.max_speed <= lim;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    board.limit = lim;
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh7fffffff - $urandom_range(3);
      1: return 32'sh80000000 + $urandom_range(3);
      2: return $signed($urandom_range(4000) - 2000);
      3: return $signed($urandom_range(32'h60000) - 32'h30000);
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic signed [31:0] rand_limit();
    case ($urandom_range(4))
      0: return 0;
      1: return 32'sh80000000;
      2: return 32'sh7fffffff;
      3: return $signed($urandom_range(32'h40000) - 32'h20000);
      default: return $signed($urandom());
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Extremes, first with clamping off, then under several limits: saturating position, saturated speed, no-op.
    send_request(OP_LOAD_POS, 32'sh7ffffff0, 32'sh80000010);
    send_request(OP_LOAD_VEL, 32'sh7fffffff, 32'sh80000000);
    send_request(OP_TICK, 0, 0);
    send_request(OP_NOP, 32'sh12345678, -1);
    send_request(OP_LOAD_VEL, 32'sh80000000, 32'sh80000000);
    send_request(OP_TICK, 32'shffffffff, 32'shffffffff);
    write_limit(32'sh80000000);
    send_request(OP_TICK, 0, 0);
    send_request(OP_LOAD_VEL, 32'sh80000000, 0);
    send_request(OP_TICK, 0, 0);
    write_limit(32'sh00010000);
    send_request(OP_LOAD_VEL, 32'sh00030000, -32'sh00040000);
    send_request(OP_TICK, 0, 0);
    send_request(OP_LOAD_VEL, 32'sh00010000, 0);
    send_request(OP_TICK, 0, 0);
    write_limit(-32'sh00020000);
    send_request(OP_LOAD_VEL, 32'sh00050000, 32'sh00050000);
    send_request(OP_TICK, 0, 0);
    write_limit(32'sh7fffffff);
    send_request(OP_LOAD_VEL, 32'sh80000000, 32'sh7fffffff);
    send_request(OP_TICK, 0, 0);
    // Long result hold-off while requests keep coming, so the input stalls.
    hold_cycles = 600;
    for (int i = 0; i < 4; i++) send_request(OP_TICK, 0, 0);
    for (int ph = 0; ph < 15; ph++) begin
      write_limit(rand_limit());
      quiet_phase = (ph == 7);
      for (int i = 0; i < 48; i++) begin
        int r;
        r = $urandom_range(9);
        if (r < 5) send_request(OP_TICK, rand_value(), rand_value());
        else if (r < 7) send_request(OP_LOAD_POS, rand_value(), rand_value());
        else if (r < 9) send_request(OP_LOAD_VEL, rand_value(), rand_value());
        else send_request(OP_NOP, rand_value(), rand_value());
      end
      quiet_phase = 0;
    end
    drain();
    if (board.errors == 0) $display("speed_clamped_motion_integrator: match");
    else $display("speed_clamped_motion_integrator: mismatch");
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("speed_clamped_motion_integrator: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
